@@ src/ofc_pkg.sv @@
// Shared types and constants for the oldest-first size-limited cache.
`default_nettype none

package ofc_pkg;

  localparam int OPCODE_W    = 2;
  localparam int KIND_W      = 3;
  localparam int ID_W        = 31;
  localparam int SIZE_W      = 32;
  localparam int AGE_W       = 32;
  localparam int TOTAL_W     = 36;
  localparam int OCC_W       = 5;
  localparam int LIMIT_W     = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  localparam logic [LIMIT_W-1:0] COUNT_LIMIT_RESET = 5'd16;
  localparam logic [SIZE_W-1:0]  SIZE_LIMIT_RESET  = 32'd20000000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EVICTED  = 3'd0,
    KIND_INSERTED = 3'd1,
    KIND_REJECTED = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_CLEARED  = 3'd4
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COUNT_LIMIT = 1'b0,
    CFG_SIZE_LIMIT  = 1'b1
  } cfg_index_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [AGE_W-1:0]  age;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } slot_t;

endpackage

`default_nettype wire

@@ src/ofc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ofc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/oldest_first_size_limited_cache_unit.sv @@
// Top level of the oldest-first size-limited cache.
//
// The block holds up to SLOTS entries (id, size, insertion age) in one slot
// memory with a registered read, plus an entry count, a running size total
// and an age counter in registers. One beat on the input stream is one
// operation (tuser: 0 insert, 1 expire oldest, 2 clear, 3 no-op); each
// operation but the no-op yields its results on the output stream, the
// final one marked by tlast. Every eviction is one pass over the memory: it
// reads slots 0..count-1, one per cycle, keeping the oldest age below the
// age counter (ties to the lowest slot), then writes the last entry into
// the freed slot and reports the evicted entry. An insert runs one pass per
// eviction; evictions run while the count is over its limit (one pass) or
// the size total is over its limit and still falls. The memory port
// carries one access of each kind per cycle, so scans never overlap a
// write-back: the sequencer finishes the write before the next pass
// starts reading. The output stage is a register, so the next beat is
// taken while the last result waits; the sequencer stalls in its evict,
// decide and clear states only while that register is still full.
// Configuration writes are taken at any time and are meant to land while
// the block is idle.
`default_nettype none

module oldest_first_size_limited_cache_unit #(
  parameter int SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream: tdata = entry_id[30:0], entry_size[62:31], zero pad [63]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ofc_pkg::IN_TDATA_W-1:0]    s_tdata,
  // tuser = opcode[1:0]
  input  logic [ofc_pkg::OPCODE_W-1:0]      s_tuser,
  // output stream: tdata = item_id[30:0], item_size[62:31],
  // occupancy[67:63], total_size[103:68]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ofc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // tuser = kind[2:0]
  output logic [ofc_pkg::KIND_W-1:0]        m_tuser,
  output logic                              m_tlast,
  // configuration writes: index 0 count_limit, index 1 size_limit
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ofc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ofc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import ofc_pkg::*;

  localparam int AW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_DECIDE,
    ST_CLEAR
  } state_t;

  state_t             state;
  opcode_t            op;
  logic [ID_W-1:0]    in_id;
  logic [SIZE_W-1:0]  in_size;
  logic [CW-1:0]      count;
  logic [TOTAL_W-1:0] total;
  logic [AGE_W-1:0]   age_ctr;
  logic [LIMIT_W-1:0] count_limit;
  logic [SIZE_W-1:0]  size_limit;

  // scan bookkeeping
  logic [CW-1:0]      idx;
  logic [AW-1:0]      best_idx;
  logic [AGE_W-1:0]   best_age;
  logic [ID_W-1:0]    best_id;
  logic [SIZE_W-1:0]  best_size;
  logic               found;
  slot_t              last_slot;

  // output register
  kind_t              out_kind;
  logic [ID_W-1:0]    out_id;
  logic [SIZE_W-1:0]  out_size;
  logic [OCC_W-1:0]   out_occ;
  logic [TOTAL_W-1:0] out_total;
  logic               out_last;

  // slot memory port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  slot_t              ram_wdata;
  slot_t              rd_slot;

  logic               out_free;
  logic               out_load;
  logic               over;
  logic               reject;
  logic               cand_hit;
  logic [TOTAL_W-1:0] evict_total;
  logic [TOTAL_W-1:0] ins_total;
  logic               keep_evicting;
  logic [CW-1:0]      idx_prev;

  ofc_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rd_slot)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {out_total, out_occ, out_size, out_id};
  assign m_tuser   = out_kind;
  assign m_tlast   = out_last;

  always_comb begin
    out_free      = !m_tvalid || m_tready;
    // a fresh result enters the output register this cycle
    out_load      = out_free &&
                    (((state == ST_EVICT) && (found || (op == OP_EXPIRE))) ||
                     (state == ST_DECIDE) || (state == ST_CLEAR));
    over          = (CMPW'(count) > CMPW'(count_limit)) ||
                    (total > TOTAL_W'(size_limit));
    reject        = (count_limit == '0) || (size_limit == '0) ||
                    (CMPW'(count) + CMPW'(1) >= CMPW'(count_limit)) ||
                    (CMPW'(count) >= CMPW'(SLOTS));
    idx_prev      = idx - CW'(1);
    // data in rd_slot belongs to the slot addressed last cycle
    cand_hit      = (idx != '0) && (rd_slot.age < best_age);
    evict_total   = total - TOTAL_W'(best_size);
    ins_total     = total + TOTAL_W'(in_size);
    keep_evicting = (evict_total > TOTAL_W'(size_limit)) && (evict_total < total);

    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = last_slot;
    case (state)
      ST_EVICT: begin
        // fill the freed slot with the last entry
        ram_we = out_free && found;
      end
      ST_DECIDE: begin
        ram_we          = out_free && !reject;
        ram_waddr       = count[AW-1:0];
        ram_wdata.age   = age_ctr;
        ram_wdata.size  = in_size;
        ram_wdata.id    = in_id;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      total       <= '0;
      age_ctr     <= '0;
      count_limit <= COUNT_LIMIT_RESET;
      size_limit  <= SIZE_LIMIT_RESET;
      m_tvalid    <= 1'b0;
      idx         <= '0;
      found       <= 1'b0;
    end else begin
      // load a fresh result, or drop the beat once it is taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COUNT_LIMIT: count_limit <= cfg_data[LIMIT_W-1:0];
          CFG_SIZE_LIMIT:  size_limit  <= cfg_data[SIZE_W-1:0];
          default:         count_limit <= count_limit;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op       <= opcode_t'(s_tuser);
            in_id    <= s_tdata[ID_W-1:0];
            in_size  <= s_tdata[ID_W+SIZE_W-1:ID_W];
            idx      <= '0;
            best_age <= age_ctr;
            found    <= 1'b0;
            case (opcode_t'(s_tuser))
              OP_INSERT: state <= over ? ST_SCAN : ST_DECIDE;
              OP_EXPIRE: state <= ST_SCAN;
              OP_CLEAR:  state <= ST_CLEAR;
              default:   state <= ST_IDLE;
            endcase
          end
        end

        ST_SCAN: begin
          if (cand_hit) begin
            best_age  <= rd_slot.age;
            best_idx  <= idx_prev[AW-1:0];
            best_id   <= rd_slot.id;
            best_size <= rd_slot.size;
            found     <= 1'b1;
          end
          if (idx == count) begin
            // hold the last entry; it moves into the freed slot
            last_slot <= rd_slot;
            state     <= ST_EVICT;
          end else begin
            idx <= idx + CW'(1);
          end
        end

        ST_EVICT: begin
          if (out_free) begin
            if (found) begin
              count     <= count - CW'(1);
              total     <= evict_total;
              out_kind  <= KIND_EVICTED;
              out_id    <= best_id;
              out_size  <= best_size;
              out_occ   <= OCC_W'(count - CW'(1));
              out_total <= evict_total;
              out_last  <= (op == OP_EXPIRE);
              idx       <= '0;
              found     <= 1'b0;
              best_age  <= age_ctr;
              if (op == OP_EXPIRE) begin
                state <= ST_IDLE;
              end else if (keep_evicting) begin
                state <= ST_SCAN;
              end else begin
                state <= ST_DECIDE;
              end
            end else if (op == OP_EXPIRE) begin
              out_kind  <= KIND_EMPTY;
              out_id    <= '0;
              out_size  <= '0;
              out_occ   <= OCC_W'(count);
              out_total <= total;
              out_last  <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              state <= ST_DECIDE;
            end
          end
        end

        ST_DECIDE: begin
          if (out_free) begin
            out_id   <= in_id;
            out_size <= in_size;
            out_last <= 1'b1;
            if (reject) begin
              out_kind  <= KIND_REJECTED;
              out_occ   <= OCC_W'(count);
              out_total <= total;
            end else begin
              age_ctr   <= age_ctr + AGE_W'(1);
              count     <= count + CW'(1);
              total     <= ins_total;
              out_kind  <= KIND_INSERTED;
              out_occ   <= OCC_W'(count + CW'(1));
              out_total <= ins_total;
            end
            state <= ST_IDLE;
          end
        end

        ST_CLEAR: begin
          if (out_free) begin
            count     <= '0;
            total     <= '0;
            age_ctr   <= '0;
            out_kind  <= KIND_CLEARED;
            out_id    <= '0;
            out_size  <= '0;
            out_occ   <= '0;
            out_total <= '0;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= CMPW'(SLOTS))
    else $error("entry count above slot capacity");

  a_mid_is_eviction: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == KIND_EVICTED)
    else $error("non-final result that is not an eviction");

  a_scan_holds_table: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |=> $stable(count) && $stable(total))
    else $error("table bookkeeping changed during a scan");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_CLEARED |-> count == '0 && total == '0)
    else $error("cleared result while table not empty");

endmodule

`default_nettype wire
